[design/cuckoo_hash_set_core_macros.svh]
// assertion macros shared by the cuckoo hash set checker
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef CUCKOO_HASH_SET_CORE_MACROS_SVH
`define CUCKOO_HASH_SET_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define CHS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define CHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/chs_pkg.sv]
// shared constants and types of the cuckoo hash set core
// no dependencies
package chs_pkg;

    // default sizes
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 31;

    // register field widths
    localparam int COEF_W    = 31;
    localparam int TS_W      = 11;
    localparam int MK_W      = 7;
    localparam int CFG_IDX_W = 3;

    // bit-serial remainder unit
    localparam int MOD_XW    = 64;
    localparam int MOD_CNT_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MUL_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUL_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_KICKS  = 3'd6;

    // register reset values
    localparam logic [COEF_W-1:0] RST_MUL_FIRST  = 31'd1;
    localparam logic [COEF_W-1:0] RST_ADD_FIRST  = 31'd0;
    localparam logic [COEF_W-1:0] RST_MUL_SECOND = 31'd3;
    localparam logic [COEF_W-1:0] RST_ADD_SECOND = 31'd7;
    localparam logic [COEF_W-1:0] RST_PRIME      = 31'd2147483647;
    localparam logic [TS_W-1:0]   RST_TABLE_SIZE = 11'd1024;
    localparam logic [MK_W-1:0]   RST_MAX_KICKS  = 7'd16;

    // operation codes; anything else is a lookup
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_NO_CHANGE  = 2'd1,
        ST_FULL       = 2'd2,
        ST_EVICT_FAIL = 2'd3
    } t_status;

endpackage

[design/chs_ram.sv]
// generic single-port ram with registered read
// no dependencies
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/cuckoo_hash_set_core.sv]
// cuckoo hash set core: two slot tables in rams, serial hashing, eviction sequencer
// depends on chs_pkg and chs_ram
//
// Holds a set of keys in two tables of TABLE_DEPTH slots, one ram each. Every request
// (insert, remove or lookup) is handled one at a time and answered by one result. Each
// slot index is computed by a single shared bit-serial remainder unit, one bit a cycle:
// key mod p, a 31x31 product plus offset, then that sum mod p and the result mod the
// table size. A request needs two hashes plus acceptance, table access and the result;
// an insert that has to evict adds a hash, a slot read and a slot write for each table
// visited, up to two visits per round over max_kicks rounds. After reset a clearing
// pass writes every slot of both tables, during which no request is accepted;
// configuration writes are taken at any time. A new request is accepted while the
// previous result still waits to be taken.
module cuckoo_hash_set_core #(
    parameter int TABLE_DEPTH = chs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = chs_pkg::DEF_KEY_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [chs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [chs_pkg::COEF_W-1:0]        i_cfg_data,
    // requests
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic [KEY_BITS-1:0]               i_key,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic                              o_present,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  o_element_total,
    output logic [KEY_BITS-1:0]               o_dropped_key
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EW    = KEY_BITS + 1;
    localparam int CW    = chs_pkg::COEF_W;
    localparam int XW    = chs_pkg::MOD_XW;
    localparam int NW    = chs_pkg::MOD_CNT_W;

    // hash phases; bit 0 selects the second table
    localparam logic [1:0] PH_LOOK1 = 2'd0;
    localparam logic [1:0] PH_LOOK2 = 2'd1;
    localparam logic [1:0] PH_KICK1 = 2'd2;
    localparam logic [1:0] PH_KICK2 = 2'd3;

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b0000_0000_0001,
        S_IDLE    = 12'b0000_0000_0010,
        S_KMOD    = 12'b0000_0000_0100,
        S_MUL     = 12'b0000_0000_1000,
        S_ADD     = 12'b0000_0001_0000,
        S_PMOD    = 12'b0000_0010_0000,
        S_SMOD    = 12'b0000_0100_0000,
        S_LOOKRD  = 12'b0000_1000_0000,
        S_LOOKCHK = 12'b0001_0000_0000,
        S_KICKRD  = 12'b0010_0000_0000,
        S_KICKWR  = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    // configuration registers
    logic [CW-1:0]               r_mul_first, r_add_first, r_mul_second, r_add_second;
    logic [CW-1:0]               r_prime;
    logic [chs_pkg::TS_W-1:0]    r_table_size;
    logic [chs_pkg::MK_W-1:0]    r_max_kicks;

    // control and payload registers
    t_state                      r_state, n_state;
    logic [1:0]                  r_phase, n_phase;
    logic [1:0]                  r_op, n_op;
    logic [KEY_BITS-1:0]         r_key, n_key;
    logic [KEY_BITS-1:0]         r_carry, n_carry;
    logic [XW-1:0]               r_mod_x, n_mod_x;
    logic [CW-1:0]               r_mod_r, n_mod_r;
    logic [CW-1:0]               r_mod_m, n_mod_m;
    logic [NW-1:0]               r_mod_cnt, n_mod_cnt;
    logic [2*CW-1:0]             r_prod, n_prod;
    logic [AW-1:0]               r_s1, n_s1, r_s2, n_s2, r_slot, n_slot;
    logic [chs_pkg::MK_W-1:0]    r_round, n_round;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_found, n_found;
    chs_pkg::t_status            r_res_status, n_res_status;
    logic [KEY_BITS-1:0]         r_res_drop, n_res_drop;
    logic [AW-1:0]               r_clr_idx, n_clr_idx;
    logic                        r_out_valid, n_out_valid;
    chs_pkg::t_status            r_out_status, n_out_status;
    logic                        r_out_present, n_out_present;
    logic [CNT_W-1:0]            r_out_total, n_out_total;
    logic [KEY_BITS-1:0]         r_out_drop, n_out_drop;

    // ram ports
    logic                        first_en, first_we, second_en, second_we;
    logic [AW-1:0]               first_addr, second_addr;
    logic [EW-1:0]               first_wdata, second_wdata, first_rdata, second_rdata;

    // helpers
    logic [CW-1:0]               p_eff, size_eff;
    logic [CW:0]                 step_t;
    logic [CW-1:0]               step_r;
    logic                        start_hash;
    logic [KEY_BITS-1:0]         hash_src;
    logic [EW-1:0]               kick_e;
    logic [2*CW:0]               hash_sum;
    logic                        in1, in2;

    chs_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_first_ram (
        .i_clk   (i_clk),
        .i_en    (first_en),
        .i_we    (first_we),
        .i_addr  (first_addr),
        .i_wdata (first_wdata),
        .o_rdata (first_rdata)
    );

    chs_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_second_ram (
        .i_clk   (i_clk),
        .i_en    (second_en),
        .i_we    (second_we),
        .i_addr  (second_addr),
        .i_wdata (second_wdata),
        .o_rdata (second_rdata)
    );

    // effective modulus and table size
    always_comb begin
        p_eff = (r_prime < CW'(2)) ? CW'(1) : r_prime;
        if (r_table_size == '0) begin
            size_eff = CW'(1);
        end else if (32'(r_table_size) > 32'(TABLE_DEPTH)) begin
            size_eff = CW'(TABLE_DEPTH);
        end else begin
            size_eff = CW'(r_table_size);
        end
    end

    // one restoring remainder step
    assign step_t   = {r_mod_r, r_mod_x[XW-1]};
    assign step_r   = (step_t >= {1'b0, r_mod_m}) ? CW'(step_t - {1'b0, r_mod_m})
                                                  : step_t[CW-1:0];
    assign hash_sum = {1'b0, r_prod} + (2*CW+1)'(r_phase[0] ? r_add_second : r_add_first);
    assign kick_e   = r_phase[0] ? second_rdata : first_rdata;
    assign in1      = first_rdata[KEY_BITS] && (first_rdata[KEY_BITS-1:0] == r_key);
    assign in2      = second_rdata[KEY_BITS] && (second_rdata[KEY_BITS-1:0] == r_key);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_op         = r_op;
        n_key        = r_key;
        n_carry      = r_carry;
        n_mod_x      = r_mod_x;
        n_mod_r      = r_mod_r;
        n_mod_m      = r_mod_m;
        n_mod_cnt    = r_mod_cnt;
        n_prod       = r_prod;
        n_s1         = r_s1;
        n_s2         = r_s2;
        n_slot       = r_slot;
        n_round      = r_round;
        n_count      = r_count;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_drop   = r_res_drop;
        n_clr_idx    = r_clr_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_present = r_out_present;
        n_out_total  = r_out_total;
        n_out_drop   = r_out_drop;
        first_en     = 1'b0;
        first_we     = 1'b0;
        first_addr   = r_s1;
        first_wdata  = {1'b1, r_key};
        second_en    = 1'b0;
        second_we    = 1'b0;
        second_addr  = r_s2;
        second_wdata = {1'b1, r_key};
        start_hash   = 1'b0;
        hash_src     = r_carry;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                first_en     = 1'b1;
                first_we     = 1'b1;
                first_addr   = r_clr_idx;
                first_wdata  = '0;
                second_en    = 1'b1;
                second_we    = 1'b1;
                second_addr  = r_clr_idx;
                second_wdata = '0;
                n_clr_idx    = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op         = i_operation;
                    n_key        = i_key;
                    n_carry      = i_key;
                    n_res_drop   = '0;
                    n_res_status = chs_pkg::ST_DONE;
                    n_phase      = PH_LOOK1;
                    start_hash   = 1'b1;
                    hash_src     = i_key;
                end
            end
            S_KMOD: begin
                if (r_mod_cnt != '0) begin
                    n_mod_r   = step_r;
                    n_mod_x   = r_mod_x << 1;
                    n_mod_cnt = r_mod_cnt - NW'(1);
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = (2*CW)'(r_phase[0] ? r_mul_second : r_mul_first)
                        * (2*CW)'(r_mod_r);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_mod_x   = {hash_sum, 1'b0};
                n_mod_r   = '0;
                n_mod_m   = p_eff;
                n_mod_cnt = NW'(2*CW + 1);
                n_state   = S_PMOD;
            end
            S_PMOD: begin
                if (r_mod_cnt != '0) begin
                    n_mod_r   = step_r;
                    n_mod_x   = r_mod_x << 1;
                    n_mod_cnt = r_mod_cnt - NW'(1);
                end else begin
                    n_mod_x   = {r_mod_r, {(XW-CW){1'b0}}};
                    n_mod_r   = '0;
                    n_mod_m   = size_eff;
                    n_mod_cnt = NW'(CW);
                    n_state   = S_SMOD;
                end
            end
            S_SMOD: begin
                if (r_mod_cnt != '0) begin
                    n_mod_r   = step_r;
                    n_mod_x   = r_mod_x << 1;
                    n_mod_cnt = r_mod_cnt - NW'(1);
                end else begin
                    case (r_phase)
                        PH_LOOK1: begin
                            n_s1       = r_mod_r[AW-1:0];
                            n_phase    = PH_LOOK2;
                            start_hash = 1'b1;
                        end
                        PH_LOOK2: begin
                            n_s2    = r_mod_r[AW-1:0];
                            n_state = S_LOOKRD;
                        end
                        default: begin
                            n_slot  = r_mod_r[AW-1:0];
                            n_state = S_KICKRD;
                        end
                    endcase
                end
            end
            S_LOOKRD: begin
                first_en  = 1'b1;
                second_en = 1'b1;
                n_state   = S_LOOKCHK;
            end
            S_LOOKCHK: begin
                n_found = in1 || in2;
                n_state = S_DONE;
                if (r_op == chs_pkg::OP_INSERT) begin
                    if (in1 || in2) begin
                        n_res_status = chs_pkg::ST_NO_CHANGE;
                    end else if (32'(r_count) >= 32'(size_eff)) begin
                        n_res_status = chs_pkg::ST_FULL;
                    end else if (!first_rdata[KEY_BITS]) begin
                        first_en = 1'b1;
                        first_we = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end else if (!second_rdata[KEY_BITS]) begin
                        second_en = 1'b1;
                        second_we = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end else if (r_max_kicks == '0) begin
                        n_res_status = chs_pkg::ST_EVICT_FAIL;
                        n_res_drop   = r_key;
                    end else begin
                        n_round    = '0;
                        n_phase    = PH_KICK1;
                        start_hash = 1'b1;
                    end
                end else if (r_op == chs_pkg::OP_REMOVE) begin
                    if (!(in1 || in2)) begin
                        n_res_status = chs_pkg::ST_NO_CHANGE;
                    end else begin
                        if (in1) begin
                            first_en    = 1'b1;
                            first_we    = 1'b1;
                            first_wdata = '0;
                        end else begin
                            second_en    = 1'b1;
                            second_we    = 1'b1;
                            second_wdata = '0;
                        end
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
            end
            S_KICKRD: begin
                first_addr  = r_slot;
                second_addr = r_slot;
                first_en    = !r_phase[0];
                second_en   = r_phase[0];
                n_state     = S_KICKWR;
            end
            S_KICKWR: begin
                // place the carried key, pick up the resident if any
                first_addr   = r_slot;
                second_addr  = r_slot;
                first_wdata  = {1'b1, r_carry};
                second_wdata = {1'b1, r_carry};
                first_en     = !r_phase[0];
                first_we     = !r_phase[0];
                second_en    = r_phase[0];
                second_we    = r_phase[0];
                n_state      = S_DONE;
                if (!kick_e[KEY_BITS]) begin
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_carry  = kick_e[KEY_BITS-1:0];
                    hash_src = kick_e[KEY_BITS-1:0];
                    if (r_phase == PH_KICK1) begin
                        n_phase    = PH_KICK2;
                        start_hash = 1'b1;
                    end else begin
                        n_round = r_round + chs_pkg::MK_W'(1);
                        if (n_round >= r_max_kicks) begin
                            n_res_status = chs_pkg::ST_EVICT_FAIL;
                            n_res_drop   = kick_e[KEY_BITS-1:0];
                        end else begin
                            n_phase    = PH_KICK1;
                            start_hash = 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_present = r_found;
                    n_out_total   = r_count;
                    n_out_drop    = r_res_drop;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // load the remainder unit with key mod p
        if (start_hash) begin
            n_mod_x   = {hash_src, {(XW-KEY_BITS){1'b0}}};
            n_mod_r   = '0;
            n_mod_m   = p_eff;
            n_mod_cnt = NW'(KEY_BITS);
            n_state   = S_KMOD;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_phase       <= n_phase;
        r_op          <= n_op;
        r_key         <= n_key;
        r_carry       <= n_carry;
        r_mod_x       <= n_mod_x;
        r_mod_r       <= n_mod_r;
        r_mod_m       <= n_mod_m;
        r_mod_cnt     <= n_mod_cnt;
        r_prod        <= n_prod;
        r_s1          <= n_s1;
        r_s2          <= n_s2;
        r_slot        <= n_slot;
        r_round       <= n_round;
        r_found       <= n_found;
        r_res_status  <= n_res_status;
        r_res_drop    <= n_res_drop;
        r_out_status  <= n_out_status;
        r_out_present <= n_out_present;
        r_out_total   <= n_out_total;
        r_out_drop    <= n_out_drop;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_first  <= chs_pkg::RST_MUL_FIRST;
            r_add_first  <= chs_pkg::RST_ADD_FIRST;
            r_mul_second <= chs_pkg::RST_MUL_SECOND;
            r_add_second <= chs_pkg::RST_ADD_SECOND;
            r_prime      <= chs_pkg::RST_PRIME;
            r_table_size <= chs_pkg::RST_TABLE_SIZE;
            r_max_kicks  <= chs_pkg::RST_MAX_KICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                chs_pkg::REG_MUL_FIRST:  r_mul_first  <= i_cfg_data;
                chs_pkg::REG_ADD_FIRST:  r_add_first  <= i_cfg_data;
                chs_pkg::REG_MUL_SECOND: r_mul_second <= i_cfg_data;
                chs_pkg::REG_ADD_SECOND: r_add_second <= i_cfg_data;
                chs_pkg::REG_PRIME:      r_prime      <= i_cfg_data;
                chs_pkg::REG_TABLE_SIZE: r_table_size <= i_cfg_data[chs_pkg::TS_W-1:0];
                chs_pkg::REG_MAX_KICKS:  r_max_kicks  <= i_cfg_data[chs_pkg::MK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // result port
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_present       = r_out_present;
    assign o_element_total = r_out_total;
    assign o_dropped_key   = r_out_drop;

endmodule

[design/chs_checker.sv]
// port-level checks of the cuckoo hash set core, bound to the top level
// depends on chs_pkg and cuckoo_hash_set_core_macros.svh
`include "cuckoo_hash_set_core_macros.svh"

module chs_checker #(
    parameter int TABLE_DEPTH = chs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = chs_pkg::DEF_KEY_BITS
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [1:0]                       o_status,
    input logic                             o_present,
    input logic [$clog2(TABLE_DEPTH+1)-1:0] o_element_total,
    input logic [KEY_BITS-1:0]              o_dropped_key
);

    // a stalled result holds
    `CHS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_dropped_key) && $stable(o_element_total))

    // dropped key only reported on eviction failure
    `CHS_ASSERT_IMP(a_drop_zero, o_out_valid && (o_status != chs_pkg::ST_EVICT_FAIL), o_dropped_key == '0)

    // full or failed eviction only for a key that was absent
    `CHS_ASSERT_IMP(a_fail_absent, o_out_valid && ((o_status == chs_pkg::ST_FULL) || (o_status == chs_pkg::ST_EVICT_FAIL)), !o_present)

    // the set never holds more keys than a table has slots
    `CHS_ASSERT_IMP(a_total_bound, o_out_valid, 32'(o_element_total) <= 32'(TABLE_DEPTH))

endmodule

bind cuckoo_hash_set_core chs_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
) u_chs_checker (.*);
